// ===== hw/rtl/tcfe_pkg.sv =====
`default_nettype none

package tcfe_pkg;

   localparam int NEST_DEPTH = 8;
   localparam int CNT_W      = $clog2(NEST_DEPTH + 1);
   localparam int IDX_W      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [3:0] TYPE_LIST     = 4'd9;
   localparam logic [3:0] LIST_LONG_NIB = 4'hF;
   localparam logic [7:0] STOP_BYTE     = 8'h00;

   typedef enum logic [2:0] {
      MODE_ZZ_FIELD  = 3'd0,
      MODE_VAR_FIELD = 3'd1,
      MODE_LIST      = 3'd2,
      MODE_STRUCT    = 3'd3,
      MODE_STOP      = 3'd4,
      MODE_ZZ_ELEM   = 3'd5,
      MODE_VAR_ELEM  = 3'd6,
      MODE_RAW       = 3'd7
   } mode_type;

   // byte run of one command: lead byte, zigzag id varint, mid byte, value varint
   typedef struct packed {
      logic        err;
      logic        b0_v;
      logic [7:0]  b0;
      logic        idv_v;
      logic [15:0] idv;
      logic        b1_v;
      logic [7:0]  b1;
      logic        vr_v;
      logic [63:0] vr;
   } desc_type;

   function automatic logic [63:0] zigzag64(input logic [63:0] v);
      return {v[62:0], 1'b0} ^ {64{v[63]}};
   endfunction

   function automatic logic [15:0] zigzag16(input logic [15:0] v);
      return {v[14:0], 1'b0} ^ {16{v[15]}};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcfe_front.sv =====
`default_nettype none

module tcfe_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [2:0]        mode,
   input  wire logic [15:0]       hdr_id,
   input  wire logic [3:0]        type_code,
   input  wire logic [63:0]       value,
   output tcfe_pkg::desc_type     desc
);
   import tcfe_pkg::*;

   logic [15:0]      last_id_ff, last_id_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      stack_ff [NEST_DEPTH];
   logic             push_en;
   logic [IDX_W-1:0] push_idx, pop_idx;
   logic [CNT_W-1:0] cnt_dec;
   logic [15:0]      delta;
   logic [3:0]       htype;
   mode_type         m;
   desc_type         d;

   assign m        = mode_type'(mode);
   assign cnt_dec  = cnt_ff - CNT_W'(1);
   assign push_idx = cnt_ff[IDX_W-1:0];
   assign pop_idx  = cnt_dec[IDX_W-1:0];
   assign delta    = hdr_id - last_id_ff;
   assign htype    = (m == MODE_LIST) ? TYPE_LIST : type_code;

   always_comb begin
      d          = '0;
      last_id_in = last_id_ff;
      cnt_in     = cnt_ff;
      push_en    = 1'b0;
      d.b0_v     = 1'b1;
      if (delta != 16'd0 && delta[15:4] == 12'd0) begin
         d.b0 = {delta[3:0], htype};
      end else begin
         d.b0    = {4'h0, htype};
         d.idv_v = 1'b1;
         d.idv   = zigzag16(hdr_id);
      end
      case (m)
         MODE_ZZ_FIELD: begin
            d.vr_v     = 1'b1;
            d.vr       = zigzag64(value);
            last_id_in = hdr_id;
         end
         MODE_VAR_FIELD: begin
            d.vr_v     = 1'b1;
            d.vr       = value;
            last_id_in = hdr_id;
         end
         MODE_LIST: begin
            d.b1_v     = 1'b1;
            last_id_in = hdr_id;
            if (value[63:4] == 60'd0 && value[3:0] != 4'hF) begin
               d.b1 = {value[3:0], type_code};
            end else begin
               d.b1   = {LIST_LONG_NIB, type_code};
               d.vr_v = 1'b1;
               d.vr   = value;
            end
         end
         MODE_STRUCT: begin
            last_id_in = '0;
            if (cnt_ff < CNT_W'(NEST_DEPTH)) begin
               push_en = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end else begin
               d.err = 1'b1;
            end
         end
         MODE_STOP: begin
            d.b0    = STOP_BYTE;
            d.idv_v = 1'b0;
            if (cnt_ff != '0) begin
               cnt_in     = cnt_dec;
               last_id_in = stack_ff[pop_idx];
            end else begin
               d.err = 1'b1;
            end
         end
         MODE_ZZ_ELEM: begin
            d.b0_v  = 1'b0;
            d.idv_v = 1'b0;
            d.vr_v  = 1'b1;
            d.vr    = zigzag64(value);
         end
         MODE_VAR_ELEM: begin
            d.b0_v  = 1'b0;
            d.idv_v = 1'b0;
            d.vr_v  = 1'b1;
            d.vr    = value;
         end
         default: begin
            d.b0    = value[7:0];
            d.idv_v = 1'b0;
         end
      endcase
   end

   assign desc = d;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_id_ff <= '0;
         cnt_ff     <= '0;
      end else if (accept) begin
         last_id_ff <= last_id_in;
         cnt_ff     <= cnt_in;
      end
   end

   // struct begin pushes the new field id
   always_ff @(posedge clock) begin
      if (accept && push_en) begin
         stack_ff[push_idx] <= hdr_id;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tcfe_queue.sv =====
`default_nettype none

module tcfe_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tcfe_pkg::desc_type push_data,
   input  wire logic              pop,
   output tcfe_pkg::desc_type     pop_data,
   output logic                   full,
   output logic                   not_empty
);
   import tcfe_pkg::*;

   desc_type           mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tcfe_back.sv =====
`default_nettype none

module tcfe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire tcfe_pkg::desc_type q_data,
   output logic                   q_pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_last,
   output logic                   out_err
);
   import tcfe_pkg::*;

   desc_type   cur_ff, cur_in, step;
   logic       busy, out_free, emit, is_last, load, more;
   logic [7:0] byte_sel;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;

   assign busy     = cur_ff.b0_v | cur_ff.idv_v | cur_ff.b1_v | cur_ff.vr_v;
   assign out_free = !valid_ff || out_ready;
   assign emit     = busy && out_free;

   always_comb begin
      step     = cur_ff;
      more     = 1'b0;
      byte_sel = '0;
      is_last  = 1'b0;
      if (cur_ff.b0_v) begin
         byte_sel  = cur_ff.b0;
         step.b0_v = 1'b0;
         is_last   = !(cur_ff.idv_v || cur_ff.b1_v || cur_ff.vr_v);
      end else if (cur_ff.idv_v) begin
         more       = |cur_ff.idv[15:7];
         byte_sel   = {more, cur_ff.idv[6:0]};
         step.idv   = {7'd0, cur_ff.idv[15:7]};
         step.idv_v = more;
         is_last    = !more && !cur_ff.b1_v && !cur_ff.vr_v;
      end else if (cur_ff.b1_v) begin
         byte_sel  = cur_ff.b1;
         step.b1_v = 1'b0;
         is_last   = !cur_ff.vr_v;
      end else begin
         more      = |cur_ff.vr[63:7];
         byte_sel  = {more, cur_ff.vr[6:0]};
         step.vr   = {7'd0, cur_ff.vr[63:7]};
         step.vr_v = more;
         is_last   = !more;
      end
   end

   // next word enters in the cycle of the previous word's final byte
   assign load  = q_valid && (!busy || (emit && is_last));
   assign q_pop = load;

   always_comb begin
      cur_in = cur_ff;
      if (load) begin
         cur_in = q_data;
      end else if (emit) begin
         cur_in = step;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (out_free) begin
         valid_in = emit;
         byte_in  = byte_sel;
         last_in  = is_last;
         err_in   = cur_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cur_ff   <= cur_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_err   = err_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/thrift_compact_field_encoder.sv =====
`default_nettype none

// channel   dir  tdata                                   tuser       tlast
// req_      in   [15:0] hdr_id [19:16] type_code         [2:0] mode  -
//                [83:20] value [87:84] zero
// rsp_      out  [7:0] out_byte                          [0] error   last byte of word
//
// One output byte per cycle while words are queued and rsp_ is not stalled: a command
// word gives 1 to 15 bytes, one per byte of its run, from the byte serializer in the back end.
// The front end classifies a word and updates field id and nesting state in the
// cycle it is accepted; a 2-deep queue decouples it from the serializer.
// Synchronous active-high reset clears field id, nesting depth, queue and output.
// Either side may stall; rsp_ is held in a register until taken.

module thrift_compact_field_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [87:0] req_tdata,   // hdr_id, type_code, value, pad
   input  wire logic [2:0]  req_tuser,   // mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic             rsp_tlast,
   output logic [0:0]       rsp_tuser    // error
);
   import tcfe_pkg::*;

   desc_type f_desc, q_data;
   logic     accept, q_full, q_valid, q_pop;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   tcfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_tuser),
      .hdr_id    (req_tdata[15:0]),
      .type_code (req_tdata[19:16]),
      .value     (req_tdata[83:20]),
      .desc      (f_desc)
   );

   tcfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (f_desc),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .not_empty (q_valid)
   );

   tcfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_err   (rsp_tuser[0])
   );

endmodule

`default_nettype wire

// ===== sim/tb_thrift_compact_field_encoder.sv =====
`default_nettype none

module tb_thrift_compact_field_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import tcfe_pkg::*;

   localparam int RANDOM_WORDS   = 500;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIR_ROWS       = 16;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } enc_byte_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] id;
      logic [3:0]  typ;
      logic [63:0] val;
      logic [7:0]  reps;
      logic [2:0]  n_exp;   // 0: predictor decides
      logic [23:0] exp_data;
      logic        exp_err;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;   // hdr_id, type_code, value, pad
   logic [2:0]  req_tuser  = '0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // out_byte
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;         // error

   thrift_compact_field_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // encoder state
   logic [15:0] cur_id = '0;
   logic [15:0] nest_ids [NEST_DEPTH];
   int          nest_cnt = 0;
   logic [7:0]  run_buf [16];
   int          run_len = 0;

   enc_byte_type pending_bytes [$];
   stim_row_type dir_tab [DIR_ROWS];

   int unsigned words_sent    = 0;
   int unsigned err_words     = 0;
   int unsigned bytes_checked = 0;
   int unsigned fail_count    = 0;
   int unsigned idle_cycles   = 0;
   bit          tx_calm       = 1'b0;
   bit          rx_calm       = 1'b0;
   bit          hold_req      = 1'b0;

   function automatic logic [63:0] zz_map(input logic [63:0] v);
      return (v << 1) ^ {64{v[63]}};
   endfunction

   function automatic stim_row_type mk(input mode_type m, input logic [15:0] id,
                                       input logic [3:0] typ, input logic [63:0] val,
                                       input int reps, input int n_exp,
                                       input logic [23:0] exp_data, input logic exp_err);
      stim_row_type r;
      r.mode     = m;
      r.id       = id;
      r.typ      = typ;
      r.val      = val;
      r.reps     = reps[7:0];
      r.n_exp    = n_exp[2:0];
      r.exp_data = exp_data;
      r.exp_err  = exp_err;
      return r;
   endfunction

   task automatic emit(input logic [7:0] b);
      if (run_len < 16) begin
         run_buf[run_len] = b;
         run_len++;
      end
   endtask

   task automatic emit_varint(input logic [63:0] v);
      while (v >= 64'h80) begin
         emit({1'b1, v[6:0]});
         v = v >> 7;
      end
      emit(v[7:0]);
   endtask

   task automatic emit_header(input logic [15:0] id, input logic [3:0] typ);
      logic [15:0] delta;
      delta = id - cur_id;
      if (delta >= 16'd1 && delta <= 16'd15) begin
         emit({delta[3:0], typ});
      end else begin
         emit({4'h0, typ});
         emit_varint(zz_map({{48{id[15]}}, id}));
      end
      cur_id = id;
   endtask

   task automatic encode_command(input mode_type m, input logic [15:0] id,
                                 input logic [3:0] typ, input logic [63:0] val,
                                 output logic err);
      err     = 1'b0;
      run_len = 0;
      case (m)
         MODE_ZZ_FIELD: begin
            emit_header(id, typ);
            emit_varint(zz_map(val));
         end
         MODE_VAR_FIELD: begin
            emit_header(id, typ);
            emit_varint(val);
         end
         MODE_LIST: begin
            emit_header(id, TYPE_LIST);
            if (val < 64'd15) begin
               emit({val[3:0], typ});
            end else begin
               emit({LIST_LONG_NIB, typ});
               emit_varint(val);
            end
         end
         MODE_STRUCT: begin
            emit_header(id, typ);
            if (nest_cnt < NEST_DEPTH) begin
               nest_ids[nest_cnt] = cur_id;
               nest_cnt++;
            end else begin
               err = 1'b1;
            end
            cur_id = '0;
         end
         MODE_STOP: begin
            emit(STOP_BYTE);
            if (nest_cnt > 0) begin
               nest_cnt--;
               cur_id = nest_ids[nest_cnt];
            end else begin
               err = 1'b1;
            end
         end
         MODE_ZZ_ELEM: emit_varint(zz_map(val));
         MODE_VAR_ELEM: emit_varint(val);
         default: emit(val[7:0]);
      endcase
      if (run_len > 15) run_len = 15;
   endtask

   task automatic send_word(input mode_type m, input logic [15:0] id,
                            input logic [3:0] typ, input logic [63:0] val,
                            input int n_exp, input logic [23:0] exp_data,
                            input logic exp_err);
      int           gap;
      logic         err;
      enc_byte_type w;
      if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, val, typ, id};
      req_tuser  <= m;
      do @(posedge clock); while (!req_tready);
      encode_command(m, id, typ, val, err);
      words_sent++;
      if (err) err_words++;
      if (n_exp != 0) begin
         for (int k = 0; k < n_exp; k++) begin
            w.data = exp_data[8*k +: 8];
            w.last = (k == n_exp - 1);
            w.err  = exp_err;
            pending_bytes.push_back(w);
         end
      end else begin
         for (int k = 0; k < run_len; k++) begin
            w.data = run_buf[k];
            w.last = (k == run_len - 1);
            w.err  = err;
            pending_bytes.push_back(w);
         end
      end
   endtask

   // receiver and checker
   initial begin
      int           stall;
      enc_byte_type w;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 59) == 0) rx_calm = ~rx_calm;
         if (hold_req) begin
            stall    = HOLD_CYCLES;
            hold_req = 1'b0;
         end else begin
            stall = rx_calm ? 0 : $urandom_range(0, 12);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_bytes.size() == 0) begin
            $error("unexpected word: out_byte %h last %b error %b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            fail_count++;
         end else begin
            w = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_tdata !== w.data) begin
               $error("out_byte: expected %h, actual %h", w.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== w.last) begin
               $error("last: expected %b, actual %b", w.last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser[0] !== w.err) begin
               $error("error: expected %b, actual %b", w.err, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mode_type    m;
      logic [15:0] id;
      logic [3:0]  typ;
      logic [63:0] val;
      int          r;

      dir_tab[0]  = mk(MODE_STOP,      16'd0,     4'd0,  64'd0,       1, 1, 24'h000000, 1'b1);
      dir_tab[1]  = mk(MODE_ZZ_FIELD,  16'd1,     4'd5,  64'd0,       1, 2, 24'h000015, 1'b0);
      dir_tab[2]  = mk(MODE_ZZ_FIELD,  16'd2,     4'd6,  '1,          1, 2, 24'h000116, 1'b0);
      dir_tab[3]  = mk(MODE_VAR_FIELD, 16'd17,    4'd8,  '1,          1, 0, 24'h0,      1'b0);
      dir_tab[4]  = mk(MODE_VAR_FIELD, 16'd17,    4'd8,  64'd0,       1, 3, 24'h002208, 1'b0);
      dir_tab[5]  = mk(MODE_ZZ_FIELD,  16'h8000,  4'd4,  64'h8000_0000_0000_0000,
                       1, 0, 24'h0, 1'b0);
      dir_tab[6]  = mk(MODE_ZZ_FIELD,  16'h7FFF,  4'd15, 64'h7FFF_FFFF_FFFF_FFFF,
                       1, 0, 24'h0, 1'b0);
      dir_tab[7]  = mk(MODE_LIST,      16'h8001,  4'd15, 64'd14,      1, 0, 24'h0,      1'b0);
      dir_tab[8]  = mk(MODE_LIST,      16'd0,     4'd0,  '1,          1, 0, 24'h0,      1'b0);
      dir_tab[9]  = mk(MODE_STRUCT,    16'd1,     4'd12, 64'd0, NEST_DEPTH, 1, 24'h00001C, 1'b0);
      dir_tab[10] = mk(MODE_STRUCT,    16'd1,     4'd12, 64'd0,       1, 1, 24'h00001C, 1'b1);
      dir_tab[11] = mk(MODE_STOP,      16'd0,     4'd0,  64'd0, NEST_DEPTH, 1, 24'h000000, 1'b0);
      dir_tab[12] = mk(MODE_LIST,      16'd16,    4'd3,  64'd15,      1, 0, 24'h0,      1'b0);
      dir_tab[13] = mk(MODE_ZZ_ELEM,   16'd0,     4'd0,  64'h8000_0000_0000_0000,
                       1, 0, 24'h0, 1'b0);
      dir_tab[14] = mk(MODE_VAR_ELEM,  16'd0,     4'd0,  '1,          1, 0, 24'h0,      1'b0);
      dir_tab[15] = mk(MODE_RAW,       16'd0,     4'd0,  64'h0123_4567_89AB_CD5A,
                       1, 1, 24'h00005A, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         for (int k = 0; k < dir_tab[i].reps; k++) begin
            send_word(dir_tab[i].mode, dir_tab[i].id, dir_tab[i].typ, dir_tab[i].val,
                      dir_tab[i].n_exp, dir_tab[i].exp_data, dir_tab[i].exp_err);
         end
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25)      m = MODE_ZZ_FIELD;
         else if (r < 45) m = MODE_VAR_FIELD;
         else if (r < 55) m = MODE_LIST;
         else if (r < 68) m = MODE_STRUCT;
         else if (r < 81) m = MODE_STOP;
         else if (r < 88) m = MODE_ZZ_ELEM;
         else if (r < 94) m = MODE_VAR_ELEM;
         else             m = MODE_RAW;
         // keep nesting mostly balanced, let a few over/underflows through
         if (m == MODE_STOP && nest_cnt == 0 && $urandom_range(0, 4) != 0)
            m = MODE_VAR_FIELD;
         if (m == MODE_STRUCT && nest_cnt == NEST_DEPTH && $urandom_range(0, 4) != 0)
            m = MODE_STOP;

         r = $urandom_range(0, 9);
         if (r < 8)       id = cur_id + 16'($urandom_range(1, 15));
         else if (r == 8) id = cur_id + ($urandom_range(0, 1) ? 16'd0
                                                              : 16'($urandom_range(16, 40)));
         else             id = 16'($urandom);
         typ = 4'($urandom_range(0, 15));
         val = {$urandom, $urandom};
         if ($urandom_range(0, 3) != 0) val = val >> $urandom_range(0, 63);
         if ((m == MODE_ZZ_FIELD || m == MODE_ZZ_ELEM) && $urandom_range(0, 1) != 0)
            val = ~val;
         if (m == MODE_LIST && $urandom_range(0, 2) != 0)
            val = 64'($urandom_range(0, 20));

         if (i == 100) hold_req = 1'b1;
         if (i == 250) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_bytes.size() != 0);
         end
         send_word(m, id, typ, val, 0, 24'h0, 1'b0);
      end
      req_tvalid <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d command words of all modes (%0d with nesting errors), %0d bytes",
               words_sent, err_words, bytes_checked);
      $display("Included a long output stall with input backpressure and a full drain pause.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/tcfe_pkg.sv
hw/rtl/tcfe_front.sv
hw/rtl/tcfe_queue.sv
hw/rtl/tcfe_back.sv
hw/rtl/thrift_compact_field_encoder.sv
sim/tb_thrift_compact_field_encoder.sv
